// ===== hdl/r2h_pkg.sv =====
// Shared constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package r2h_pkg;

  localparam logic [1:0] WIN_RED   = 2'd0;
  localparam logic [1:0] WIN_GREEN = 2'd1;
  localparam logic [1:0] WIN_BLUE  = 2'd2;

  localparam int SECTORS     = 6;
  localparam int GREEN_START = 2;
  localparam int BLUE_START  = 4;

endpackage

// ===== hdl/r2h_if.sv =====
// Stream interfaces for RGB pixels in and HSV pixels out.
`timescale 1ns / 1ps

interface rgb_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hsv_if #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue_out;
  logic [CHANNEL_BITS-1:0] saturation_out;
  logic [CHANNEL_BITS-1:0] value_out;

  modport source (output valid, output hue_out, output saturation_out, output value_out,
                  input ready);
  modport sink (input valid, input hue_out, input saturation_out, input value_out,
                output ready);
endinterface

// ===== hdl/rgb_to_hsv_pixel.sv =====
// Pipelined RGB to HSV pixel converter, top level.
// The converter takes one pixel per clock while the output is not stalled and
// returns each result after max(HUE_BITS, CHANNEL_BITS) + 1 register stages.
// The first stage finds the largest and smallest channel, the spread and the
// hue numerator; each later stage resolves one quotient bit of whichever of
// the hue and the saturation divisions still has bits left, by a restoring
// compare and subtract. Each stage holds its own valid bit and takes new data
// whenever it is empty or the stage after it moves, so bubbles close up and a
// stalled output does not block input until the whole pipeline is full. Grey
// and black pixels give zero hue and saturation.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel
  import r2h_pkg::*;
#(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  rgb_if.sink   in_pix,
  hsv_if.source out_pix
);

  localparam int C = CHANNEL_BITS;
  localparam int H = HUE_BITS;
  localparam int W = C + 3;
  localparam int L = (H > C) ? H : C;

  typedef struct packed {
    logic         vld;
    logic         zero;
    logic [C-1:0] hi;
    logic [W-1:0] hdiv;
    logic [W-1:0] hrem;
    logic [H-1:0] hq;
    logic [C-1:0] srem;
    logic [C-1:0] slow;
    logic [C-1:0] sq;
  } stage_t;

  stage_t     st_r [0:L];
  stage_t     st_nxt [0:L];
  logic [L:0] rdy;

  logic [C-1:0]   r_c, g_c, b_c, hi_c, lo_c, spr_c;
  logic [1:0]     win_c;
  logic [W-1:0]   six_c, num_c;
  logic [2*C-1:0] sdvd_c;

  always_comb begin
    r_c = in_pix.red_in;
    g_c = in_pix.green_in;
    b_c = in_pix.blue_in;
    if ((r_c >= g_c) && (r_c >= b_c)) begin
      win_c = WIN_RED;
      hi_c  = r_c;
    end else if (g_c >= b_c) begin
      win_c = WIN_GREEN;
      hi_c  = g_c;
    end else begin
      win_c = WIN_BLUE;
      hi_c  = b_c;
    end
    lo_c = r_c;
    if (g_c < lo_c) begin
      lo_c = g_c;
    end
    if (b_c < lo_c) begin
      lo_c = b_c;
    end
    spr_c  = hi_c - lo_c;
    six_c  = (W'(spr_c) << 2) + (W'(spr_c) << 1);
    sdvd_c = ({C'(0), spr_c} << C) - {C'(0), spr_c};
    case (win_c)
      WIN_RED: begin
        if (g_c >= b_c) begin
          num_c = W'(g_c) - W'(b_c);
        end else begin
          num_c = six_c - (W'(b_c) - W'(g_c));
        end
      end
      WIN_GREEN: begin
        num_c = W'(spr_c) * W'(GREEN_START) + W'(b_c) - W'(r_c);
      end
      default: begin
        num_c = W'(spr_c) * W'(BLUE_START) + W'(r_c) - W'(g_c);
      end
    endcase
    st_nxt[0].vld  = in_pix.valid;
    st_nxt[0].zero = (spr_c == '0);
    st_nxt[0].hi   = hi_c;
    st_nxt[0].hdiv = six_c;
    st_nxt[0].hrem = num_c;
    st_nxt[0].hq   = '0;
    st_nxt[0].srem = sdvd_c[2*C-1:C];
    st_nxt[0].slow = sdvd_c[C-1:0];
    st_nxt[0].sq   = '0;
  end

  assign rdy[0]       = !st_r[0].vld || rdy[1];
  assign in_pix.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (rdy[0]) begin
      st_r[0] <= st_nxt[0];
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_stage
    logic [W:0] ht;
    logic       hge;
    logic [C:0] stt;
    logic       sge;

    if (k == L) begin : g_last
      assign rdy[k] = !st_r[k].vld || out_pix.ready;
    end else begin : g_mid
      assign rdy[k] = !st_r[k].vld || rdy[k+1];
    end

    always_comb begin
      st_nxt[k] = st_r[k-1];
      ht  = {st_r[k-1].hrem, 1'b0};
      hge = (ht >= {1'b0, st_r[k-1].hdiv});
      stt = {st_r[k-1].srem, st_r[k-1].slow[C-1]};
      sge = (stt >= {1'b0, st_r[k-1].hi});
      if (k - 1 < H) begin
        st_nxt[k].hrem = hge ? W'(ht - {1'b0, st_r[k-1].hdiv}) : W'(ht);
        st_nxt[k].hq   = {st_r[k-1].hq[H-2:0], hge};
      end
      if (k - 1 < C) begin
        st_nxt[k].srem = sge ? C'(stt - {1'b0, st_r[k-1].hi}) : C'(stt);
        st_nxt[k].slow = {st_r[k-1].slow[C-2:0], 1'b0};
        st_nxt[k].sq   = {st_r[k-1].sq[C-2:0], sge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_pix.valid          = st_r[L].vld;
  assign out_pix.hue_out        = st_r[L].zero ? '0 : st_r[L].hq;
  assign out_pix.saturation_out = st_r[L].zero ? '0 : st_r[L].sq;
  assign out_pix.value_out      = st_r[L].hi;

endmodule

// ===== hdl/r2h_checker.sv =====
// Port-level checker for the RGB to HSV converter and its bind statement.
`timescale 1ns / 1ps

module r2h_checker #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [HUE_BITS-1:0]     hue_out,
  input logic [CHANNEL_BITS-1:0] saturation_out,
  input logic [CHANNEL_BITS-1:0] value_out
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before its transaction completed");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(hue_out) && $stable(saturation_out)
                               && $stable(value_out))
    else $error("stalled result payload changed");

  // Input is held off only when the output is backed up.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low while the output is free");

  // A grey pixel has no hue, and a black pixel no saturation.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (saturation_out == '0) |-> (hue_out == '0))
    else $error("hue nonzero with zero saturation");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (value_out == '0) |-> (saturation_out == '0))
    else $error("saturation nonzero with zero value");

endmodule

bind rgb_to_hsv_pixel r2h_checker #(
  .CHANNEL_BITS(CHANNEL_BITS),
  .HUE_BITS(HUE_BITS)
) u_r2h_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_pix.ready),
  .out_valid(out_pix.valid),
  .out_ready(out_pix.ready),
  .hue_out(out_pix.hue_out),
  .saturation_out(out_pix.saturation_out),
  .value_out(out_pix.value_out)
);
